/* hdl/palette_nearest_colour_match_core_assert.svh */
// assertion macros for the palette nearest colour match core
`ifndef PALETTE_NEAREST_COLOUR_MATCH_CORE_ASSERT_SVH
`define PALETTE_NEAREST_COLOUR_MATCH_CORE_ASSERT_SVH

// next-cycle implication, masked during reset
`define PNCM_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("pncm assertion failed");

// next-cycle implication that also holds across reset
`define PNCM_ASSERT_NEXT_ALWAYS(label, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("pncm assertion failed");

`endif

/* hdl/pncm_pkg.sv */
// shared constants, types and helpers for the palette match core
package pncm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int COLOUR_W = 24;
  localparam int ENTRY_IDX_W = 8;
  localparam int CMD_W = 2;
  localparam int BPP_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;
  localparam int DIST_W = 18;
  localparam int MATCH_LIMIT = 1024;
  localparam int LIMIT_W = 11;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MATCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 1'd1;

  localparam logic [BPP_W-1:0] BPP_RESET = 4'd8;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } pncm_tag_t;

  // highest palette index in use for a given pixel depth
  function automatic logic [IDX_W-1:0] last_index(input logic [BPP_W-1:0] bpp);
    logic [9:0] n;
    if (bpp >= 4'd9) begin
      n = 10'd512;
    end else begin
      n = 10'd1 << bpp;
    end
    if (n > 10'(PALETTE_DEPTH)) begin
      n = 10'(PALETTE_DEPTH);
    end
    return IDX_W'(n - 10'd1);
  endfunction

endpackage

/* hdl/pncm_palette_ram.sv */
// palette storage, one write port and one registered read port
module pncm_palette_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [pncm_pkg::IDX_W-1:0]     waddr,
  input  logic [pncm_pkg::COLOUR_W-1:0]  wdata,
  input  logic [pncm_pkg::IDX_W-1:0]     raddr,
  output logic [pncm_pkg::COLOUR_W-1:0]  rdata
);
  import pncm_pkg::*;

  logic [COLOUR_W-1:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pncm_dist_unit.sv */
// shared squared rgb distance pipeline, one entry per cycle
module pncm_dist_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pncm_pkg::COLOUR_W-1:0]  colour,
  input  logic [pncm_pkg::COLOUR_W-1:0]  entry,
  input  pncm_pkg::pncm_tag_t            tag_in,
  output logic [pncm_pkg::DIST_W-1:0]    sq_dist,
  output pncm_pkg::pncm_tag_t            tag_out
);
  import pncm_pkg::*;

  logic [7:0]  dr, dg, db;
  logic [15:0] sq_r, sq_g, sq_b;
  pncm_tag_t   tag1;

  always_comb begin
    dr = (colour[23:16] > entry[23:16]) ? colour[23:16] - entry[23:16]
                                        : entry[23:16] - colour[23:16];
    dg = (colour[15:8] > entry[15:8]) ? colour[15:8] - entry[15:8]
                                      : entry[15:8] - colour[15:8];
    db = (colour[7:0] > entry[7:0]) ? colour[7:0] - entry[7:0]
                                    : entry[7:0] - colour[7:0];
  end

  always_ff @(posedge clk) begin
    sq_r <= dr * dr;
    sq_g <= dg * dg;
    sq_b <= db * db;
    sq_dist <= DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    if (rst) begin
      tag1.valid    <= 1'b0;
      tag_out.valid <= 1'b0;
    end else begin
      tag1    <= tag_in;
      tag_out <= tag1;
    end
  end

endmodule

/* hdl/pncm_seq.sv */
// command sequencer: palette writes, lookups and the match scan
module pncm_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pncm_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pncm_pkg::ENTRY_IDX_W-1:0]  in_index,
  input  logic [pncm_pkg::COLOUR_W-1:0]     in_colour,
  input  logic [pncm_pkg::BPP_W-1:0]        bpp,
  input  logic                              present,
  output logic                              ram_we,
  output logic [pncm_pkg::IDX_W-1:0]        ram_waddr,
  output logic [pncm_pkg::IDX_W-1:0]        ram_raddr,
  input  logic [pncm_pkg::COLOUR_W-1:0]     ram_rdata,
  output logic [pncm_pkg::COLOUR_W-1:0]     colour,
  output pncm_pkg::pncm_tag_t               issue_tag,
  input  logic [pncm_pkg::DIST_W-1:0]       sq_dist,
  input  pncm_pkg::pncm_tag_t               dist_tag,
  output logic                              res_valid,
  output logic [pncm_pkg::COLOUR_W-1:0]     res_data,
  input  logic                              res_ready
);
  import pncm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_LOOKW = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]          state, state_next;
  logic [IDX_W-1:0]    addr;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    best_idx;
  logic [LIMIT_W-1:0]  best_dist;
  logic                closer;
  logic                accept;
  logic [ENTRY_IDX_W-1:0] clamp_idx;

  assign last_idx  = last_index(bpp);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ram_we    = accept && (in_cmd == CMD_WRITE) &&
                     ({1'b0, in_index} < 9'(PALETTE_DEPTH));
  assign ram_waddr = IDX_W'(in_index);
  assign ram_raddr = addr;
  assign res_valid = (state == S_FIN);
  assign clamp_idx = (in_index > ENTRY_IDX_W'(last_idx)) ? ENTRY_IDX_W'(last_idx) : in_index;
  assign closer    = dist_tag.valid && (sq_dist < DIST_W'(best_dist));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_MATCH || in_cmd == CMD_LOOKUP)) begin
          if (!present) begin
            state_next = S_FIN;
          end else if (in_cmd == CMD_MATCH) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_SCAN: begin
        if (addr == last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (dist_tag.valid && dist_tag.last) begin
          state_next = S_FIN;
        end
      end
      S_LOOK:  state_next = S_LOOKW;
      S_LOOKW: state_next = S_FIN;
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      issue_tag.valid <= 1'b0;
    end else begin
      state           <= state_next;
      issue_tag.valid <= (state == S_SCAN);
    end
    issue_tag.last <= (addr == last_idx);
    issue_tag.idx  <= addr;

    if (closer) begin
      best_dist <= LIMIT_W'(sq_dist);
      best_idx  <= dist_tag.idx;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          colour    <= in_colour;
          best_dist <= LIMIT_W'(MATCH_LIMIT);
          best_idx  <= last_idx;
          res_data  <= '0;
          if (in_cmd == CMD_LOOKUP) begin
            addr <= IDX_W'(clamp_idx);
          end else begin
            addr <= '0;
          end
        end
      end
      S_SCAN: begin
        addr <= addr + 1'b1;
      end
      S_DRAIN: begin
        if (dist_tag.valid && dist_tag.last) begin
          res_data <= COLOUR_W'(closer ? dist_tag.idx : best_idx);
        end
      end
      S_LOOKW: begin
        res_data <= ram_rdata;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/palette_nearest_colour_match_core.sv */
// top level of the palette nearest colour match core
// usage:
//   s_* carries commands: tuser is the command (write, match, lookup),
//   tdata holds the entry index and the colour. m_* returns one answer for
//   each match or lookup; writes and unknown commands return nothing.
//   cfg_we/cfg_index/cfg_data set the pixel depth (index 0) and the
//   palette present flag (index 1); write them only while the core is idle.
// timing:
//   a write leaves s_tready high.
//   a lookup reads the entry, clamped to the depth, and returns its colour.
//   a match scans n entries, n = 2^bpp capped at 256: the single palette
//   read port feeds the shared distance pipeline one entry per cycle.
//   with no palette present, a query answers 0.
//   s_tready is low while a query is in flight.
// reset:
//   rst clears the handshake state and sets depth 8, no palette; palette
//   contents are undefined until written.
// stall:
//   the answer sits in the output register until taken; the next command
//   is still accepted, and its answer waits until that register frees.
module palette_nearest_colour_match_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // entry_index, rgb_colour
  input  logic [pncm_pkg::CMD_W-1:0]        s_tuser,   // cmd
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pncm_pkg::COLOUR_W-1:0]     m_tdata,   // answer
  input  logic                              cfg_we,
  input  logic [pncm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pncm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pncm_pkg::*;

  logic [BPP_W-1:0]    bpp;
  logic                present;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [COLOUR_W-1:0] ram_rdata;
  logic [COLOUR_W-1:0] colour;
  pncm_tag_t           issue_tag, dist_tag;
  logic [DIST_W-1:0]   sq_dist;
  logic                res_valid, res_ready;
  logic [COLOUR_W-1:0] res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp     <= BPP_RESET;
      present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BPP:     bpp     <= cfg_data[BPP_W-1:0];
        CFG_PRESENT: present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_ready && res_valid) begin
      m_tdata <= res_data;
    end
  end

  pncm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_index  (s_tdata[7:0]),
    .in_colour (s_tdata[31:8]),
    .bpp       (bpp),
    .present   (present),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .colour    (colour),
    .issue_tag (issue_tag),
    .sq_dist   (sq_dist),
    .dist_tag  (dist_tag),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  pncm_palette_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata[31:8]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pncm_dist_unit u_dist (
    .clk     (clk),
    .rst     (rst),
    .colour  (colour),
    .entry   (ram_rdata),
    .tag_in  (issue_tag),
    .sq_dist (sq_dist),
    .tag_out (dist_tag)
  );

endmodule

/* hdl/pncm_port_checker.sv */
// port-level checks for the palette match core, bound to the top level
`include "palette_nearest_colour_match_core_assert.svh"

module pncm_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [pncm_pkg::CMD_W-1:0]        s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [pncm_pkg::COLOUR_W-1:0]     m_tdata
);
  import pncm_pkg::*;

  // a query holds off the next command: s_tready is low in the cycle after it is taken
  `PNCM_ASSERT_NEXT(query_blocks_input,
    s_tvalid && s_tready && (s_tuser == CMD_MATCH || s_tuser == CMD_LOOKUP), !s_tready)

  // writes and unknown commands leave the input open
  `PNCM_ASSERT_NEXT(write_keeps_ready,
    s_tvalid && s_tready && s_tuser != CMD_MATCH && s_tuser != CMD_LOOKUP, s_tready)

  // a stalled answer holds
  `PNCM_ASSERT_NEXT(answer_holds,
    m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // reset empties the output register
  `PNCM_ASSERT_NEXT_ALWAYS(reset_clears_output, rst, !m_tvalid)

endmodule

bind palette_nearest_colour_match_core pncm_port_checker u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* bench/tb_top.sv */
// self-checking bench for the palette nearest colour match core
`timescale 1ns / 1ps

module tb_top;
  import pncm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS = 1100;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES = 300;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // config rows: idx is the register, colour the value
  typedef struct packed {
    row_kind_t           kind;
    logic [CMD_W-1:0]    cmd;
    logic [7:0]          idx;
    logic [23:0]         colour;
    logic                typed;
    logic [23:0]         answer;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;       // entry_index, rgb_colour
  logic [CMD_W-1:0] s_tuser = '0;  // cmd
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [COLOUR_W-1:0] m_tdata;    // answer
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [23:0] colours [256];
  logic [BPP_W-1:0] depth_now = BPP_RESET;
  logic present_now = 1'b0;
  logic [23:0] answers_due [$];
  int issued = 0;
  int faults = 0;
  bit calm = 1'b0;

  stim_row_t plan [25] = '{
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'hffffff, 1'b1, 24'h000000},
    '{ROW_CMD, CMD_LOOKUP, 8'hff, 24'h000000, 1'b1, 24'h000000},
    '{ROW_CMD, CMD_WRITE,  8'h00, 24'h000000, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_WRITE,  8'h01, 24'hffffff, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_UNUSED, 8'hff, 24'hffffff, 1'b0, 24'h000000},
    '{ROW_CFG, CMD_WRITE,  8'(CFG_BPP),     24'd1, 1'b0, 24'h000000},
    '{ROW_CFG, CMD_WRITE,  8'(CFG_PRESENT), 24'd1, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'h000000, 1'b1, 24'h000000},
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'hffffff, 1'b1, 24'h000001},
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'h808080, 1'b1, 24'h000001},
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'h0f0f0f, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'h131313, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_LOOKUP, 8'hff, 24'h000000, 1'b1, 24'hffffff},
    '{ROW_CMD, CMD_LOOKUP, 8'h00, 24'h000000, 1'b1, 24'h000000},
    '{ROW_CMD, CMD_WRITE,  8'h01, 24'h000000, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'h000000, 1'b0, 24'h000000},
    '{ROW_CFG, CMD_WRITE,  8'(CFG_BPP),     24'd0, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_MATCH,  8'h00, 24'hffffff, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_LOOKUP, 8'hc8, 24'h000000, 1'b0, 24'h000000},
    '{ROW_CFG, CMD_WRITE,  8'(CFG_PRESENT), 24'd0, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_LOOKUP, 8'h01, 24'h000000, 1'b1, 24'h000000},
    '{ROW_CMD, CMD_WRITE,  8'h01, 24'habcdef, 1'b0, 24'h000000},
    '{ROW_CFG, CMD_WRITE,  8'(CFG_PRESENT), 24'd1, 1'b0, 24'h000000},
    '{ROW_CFG, CMD_WRITE,  8'(CFG_BPP),     24'd1, 1'b0, 24'h000000},
    '{ROW_CMD, CMD_LOOKUP, 8'h01, 24'h000000, 1'b1, 24'habcdef}
  };

  palette_nearest_colour_match_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("palette_nearest_colour_match_core test failed");
    $finish;
  end

  // applies one command to the palette copy; returns 1 when it yields an answer
  function automatic bit predict_command(input logic [CMD_W-1:0] cmd, input logic [7:0] idx,
                                         input logic [23:0] colour, output logic [23:0] answer);
    int span;
    int best_dist;
    int sum_sq;
    int d;
    int best;
    answer = '0;
    if (cmd == CMD_WRITE) begin
      colours[idx] = colour;
      return 1'b0;
    end
    if (cmd != CMD_MATCH && cmd != CMD_LOOKUP) begin
      return 1'b0;
    end
    if (!present_now) begin
      return 1'b1;
    end
    span = (depth_now >= 8) ? 256 : (1 << depth_now);
    if (cmd == CMD_LOOKUP) begin
      answer = colours[(int'(idx) < span) ? int'(idx) : span - 1];
      return 1'b1;
    end
    best_dist = MATCH_LIMIT;
    best = span - 1;
    for (int i = 0; i < span; i++) begin
      sum_sq = 0;
      for (int c = 0; c < 3; c++) begin
        d = int'(colour[8*c +: 8]) - int'(colours[i][8*c +: 8]);
        sum_sq += d * d;
      end
      if (sum_sq < best_dist) begin
        best_dist = sum_sq;
        best = i;
      end
    end
    answer = 24'(best);
    return 1'b1;
  endfunction

  function automatic logic [23:0] pick_colour();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] near_colour(input logic [23:0] base);
    logic [23:0] result;
    int v;
    for (int c = 0; c < 3; c++) begin
      v = int'(base[8*c +: 8]) + $urandom_range(0, 40) - 20;
      v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      result[8*c +: 8] = 8'(v);
    end
    return result;
  endfunction

  task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [7:0] idx,
                              input logic [23:0] colour, input bit typed,
                              input logic [23:0] typed_answer);
    logic [23:0] answer;
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {colour, idx};
    do @(posedge clk); while (!s_tready);
    if (predict_command(cmd, idx, colour, answer)) begin
      answers_due.push_back(typed ? typed_answer : answer);
    end
    if (cmd != CMD_UNUSED) begin
      issued++;
    end
  endtask

  task automatic wait_idle();
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] which, input logic [CFG_DATA_W-1:0] value);
    s_tvalid <= 1'b0;
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_BPP) begin
      depth_now = value;
    end else begin
      present_now = value[0];
    end
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        $error("answer with nothing expected: actual %h", m_tdata);
        faults++;
      end else if (m_tdata !== answers_due[0]) begin
        $error("answer mismatch: expected %h, actual %h", answers_due[0], m_tdata);
        faults++;
        void'(answers_due.pop_front());
      end else begin
        void'(answers_due.pop_front());
      end
    end
  end

  initial begin
    logic [BPP_W-1:0] depth;
    int span;
    int pick;
    int phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        set_reg(plan[r].idx[CFG_IDX_W-1:0], plan[r].colour[CFG_DATA_W-1:0]);
      end else begin
        push_command(plan[r].cmd, plan[r].idx, plan[r].colour, plan[r].typed, plan[r].answer);
      end
    end

    // fill the whole palette, with some repeated colours for ties
    for (int i = 0; i < 256; i++) begin
      push_command(CMD_WRITE, 8'(i),
                   (i > 0 && $urandom_range(0, 9) == 0) ?
                     colours[$urandom_range(0, i - 1)] : pick_colour(), 1'b0, '0);
    end

    phase = 0;
    while (issued < ITEMS) begin
      if (phase == 0) begin
        depth = 4'd15;
      end else if (phase == 1) begin
        depth = 4'd8;
      end else begin
        pick = $urandom_range(0, 9);
        depth = (pick < 6) ? BPP_W'($urandom_range(0, 5)) :
                (pick < 8) ? BPP_W'($urandom_range(6, 8)) : BPP_W'($urandom_range(9, 15));
      end
      set_reg(CFG_BPP, depth);
      set_reg(CFG_PRESENT, CFG_DATA_W'($urandom_range(0, 99) < 85));
      span = (depth >= 8) ? 256 : (1 << depth);
      repeat ($urandom_range(20, 60)) begin
        calm = issued >= 500 && issued < 700;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          push_command(CMD_WRITE, 8'($urandom),
                       pick < 7 ? near_colour(colours[$urandom_range(0, 255)]) : pick_colour(),
                       1'b0, '0);
        end else if (pick < 60) begin
          push_command(CMD_MATCH, 8'($urandom),
                       pick < 42 ? near_colour(colours[$urandom_range(0, span - 1)]) :
                                   pick_colour(),
                       1'b0, '0);
        end else if (pick < 95) begin
          push_command(CMD_LOOKUP,
                       pick < 78 ? 8'($urandom_range(0, span - 1)) : 8'($urandom),
                       24'($urandom), 1'b0, '0);
        end else begin
          push_command(CMD_UNUSED, 8'($urandom), 24'($urandom), 1'b0, '0);
        end
      end
      phase++;
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (faults == 0 && answers_due.size() == 0) begin
      $display("palette_nearest_colour_match_core test passed");
    end else begin
      $display("palette_nearest_colour_match_core test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/pncm_pkg.sv
hdl/pncm_palette_ram.sv
hdl/pncm_dist_unit.sv
hdl/pncm_seq.sv
hdl/palette_nearest_colour_match_core.sv
hdl/pncm_port_checker.sv
bench/tb_top.sv
